// ----- design/bip_pkg.sv -----
// shared types and constants of the breakpoint interpolation player
package bip_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned ValW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned MagW    = ValW + 1;
  localparam int unsigned ProdW   = MagW + TimeW;
  localparam int unsigned NumW    = ProdW + 1;
  localparam int unsigned DivCntW = $clog2(NumW + 1);

  localparam logic OpTick = 1'b0;
  localparam logic OpLoad = 1'b1;

  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd1;
  localparam logic [StatusW-1:0] StatusFull  = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StStart,
    StSrchRd,
    StSrchCmp,
    StShRd,
    StShWr,
    StIns,
    StOvr,
    StMul,
    StDivInit,
    StDiv,
    StResp
  } state_e;

  typedef enum logic [2:0] {
    ResOk,
    ResEmpty,
    ResFull,
    ResCur,
    ResPrev,
    ResLoop,
    ResInterp
  } res_sel_e;

  typedef struct packed {
    logic     accept;
    logic     capture;
    logic     k_inc;
    logic     set_j;
    logic     sh_rd;
    logic     sh_wr;
    logic     ins_wr;
    logic     ovr_wr;
    logic     mul;
    logic     div_init;
    logic     div_step;
    logic     out_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic op_load;
    logic count_zero;
    logic full;
    logic k_at_end;
    logic k_zero;
    logic hit;
    logic eq;
    logic j_at_i;
    logic den_zero;
    logic div_done;
    logic out_free;
    logic loop;
  } stat_t;

endpackage

// ----- design/bip_ram.sv -----
// generic single write port ram with registered read
module bip_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- design/bip_ctrl.sv -----
// controller state machine of the breakpoint interpolation player
module bip_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bip_pkg::stat_t stat_i,
  output bip_pkg::cmd_t  cmd_o
);
  import bip_pkg::*;

  state_e   state_q, state_d;
  res_sel_e res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      res_q   <= ResOk;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StStart;
        end
      end
      StStart: begin
        if (!stat_i.op_load && stat_i.count_zero) begin
          res_d   = ResEmpty;
          state_d = StResp;
        end else begin
          state_d = StSrchRd;
        end
      end
      StSrchRd: begin
        if (!stat_i.k_at_end) begin
          state_d = StSrchCmp;
        end else if (stat_i.op_load) begin
          if (stat_i.full) begin
            res_d   = ResFull;
            state_d = StResp;
          end else begin
            state_d = StShRd;
          end
        end else begin
          res_d   = stat_i.loop ? ResLoop : ResPrev;
          state_d = StResp;
        end
      end
      StSrchCmp: begin
        if (!stat_i.hit) begin
          state_d = StSrchRd;
        end else if (stat_i.op_load) begin
          if (stat_i.eq) begin
            state_d = StOvr;
          end else if (stat_i.full) begin
            res_d   = ResFull;
            state_d = StResp;
          end else begin
            state_d = StShRd;
          end
        end else if (stat_i.k_zero) begin
          res_d   = ResCur;
          state_d = StResp;
        end else begin
          state_d = StMul;
        end
      end
      StShRd:    state_d = stat_i.j_at_i ? StIns : StShWr;
      StShWr:    state_d = StShRd;
      StIns: begin
        res_d   = ResOk;
        state_d = StResp;
      end
      StOvr: begin
        res_d   = ResOk;
        state_d = StResp;
      end
      StMul:     state_d = StDivInit;
      StDivInit: begin
        if (stat_i.den_zero) begin
          res_d   = ResCur;
          state_d = StResp;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (stat_i.div_done) begin
          res_d   = ResInterp;
          state_d = StResp;
        end
      end
      StResp: begin
        if (stat_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.res_sel = res_q;
    in_ready_o    = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      StStart: ;
      StSrchRd: ;
      StSrchCmp: begin
        cmd_o.capture = 1'b1;
        cmd_o.k_inc   = !stat_i.hit;
        cmd_o.set_j   = stat_i.hit && stat_i.op_load && !stat_i.eq;
      end
      StShRd:    cmd_o.sh_rd = !stat_i.j_at_i;
      StShWr:    cmd_o.sh_wr = 1'b1;
      StIns:     cmd_o.ins_wr = 1'b1;
      StOvr:     cmd_o.ovr_wr = 1'b1;
      StMul:     cmd_o.mul = 1'b1;
      StDivInit: cmd_o.div_init = 1'b1;
      StDiv:     cmd_o.div_step = !stat_i.div_done;
      StResp:    cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
    // load not found at end of table: insertion point is the count
    if (state_q == StSrchRd && stat_i.k_at_end && stat_i.op_load && !stat_i.full) begin
      cmd_o.set_j = 1'b1;
    end
  end
endmodule

// ----- design/bip_dp.sv -----
// datapath: breakpoint table, search pointers, interpolation and result register
module bip_dp #(
  parameter int unsigned TableDepth = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic                                op_i,
  input  logic [bip_pkg::TimeW-1:0]           entry_time_i,
  input  logic signed [bip_pkg::ValW-1:0]     entry_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bip_pkg::ValW-1:0]     value_out_o,
  output logic [bip_pkg::TimeW-1:0]           time_out_o,
  output logic [bip_pkg::StatusW-1:0]         status_o,
  input  bip_pkg::cmd_t                       cmd_i,
  output bip_pkg::stat_t                      stat_o
);
  import bip_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);

  logic [CW-1:0]    count_q, k_q, j_q;
  logic [TimeW-1:0] time_q, et_q, tprev_q, tcur_q, den_q;
  logic [ValW-1:0]  ev_q, vprev_q, vcur_q, vfirst_q;
  logic             loop_q, op_q, sign_q;
  logic [ProdW-1:0] prod_q;
  logic [NumW-1:0]  num_q;
  logic [TimeW-1:0] rem_q;
  logic [DivCntW-1:0] dcnt_q;
  logic             ovalid_q;
  logic [ValW-1:0]  oval_q;
  logic [TimeW-1:0] otime_q;
  logic [StatusW-1:0] ostat_q;

  logic             t_we, v_we;
  logic [AW-1:0]    waddr, raddr;
  logic [TimeW-1:0] t_wdata, t_rdata, target;
  logic [ValW-1:0]  v_wdata, v_rdata;

  bip_ram #(.Width(TimeW), .Depth(TableDepth)) u_time_ram (
    .clk_i, .we_i(t_we), .waddr_i(waddr), .wdata_i(t_wdata),
    .raddr_i(raddr), .rdata_o(t_rdata)
  );
  bip_ram #(.Width(ValW), .Depth(TableDepth)) u_value_ram (
    .clk_i, .we_i(v_we), .waddr_i(waddr), .wdata_i(v_wdata),
    .raddr_i(raddr), .rdata_o(v_rdata)
  );

  logic [CW-1:0] j_m1;
  assign j_m1 = j_q - CW'(1);

  always_comb begin
    raddr   = cmd_i.sh_rd ? j_m1[AW-1:0] : k_q[AW-1:0];
    t_we    = cmd_i.sh_wr | cmd_i.ins_wr;
    v_we    = cmd_i.sh_wr | cmd_i.ins_wr | cmd_i.ovr_wr;
    waddr   = cmd_i.sh_wr ? j_q[AW-1:0] : k_q[AW-1:0];
    t_wdata = cmd_i.sh_wr ? t_rdata : et_q;
    v_wdata = cmd_i.sh_wr ? v_rdata : ev_q;
  end

  assign target = op_q ? et_q : time_q;

  // interpolation operands
  logic signed [MagW-1:0] dv;
  logic [MagW-1:0]        mag;
  logic [TimeW-1:0]       dt;
  assign dv  = $signed({vcur_q[ValW-1], vcur_q}) - $signed({vprev_q[ValW-1], vprev_q});
  assign mag = dv[MagW-1] ? MagW'(-dv) : MagW'(dv);
  assign dt  = time_q - tprev_q;

  // restoring divider, one quotient bit per cycle
  logic [TimeW:0] rsh;
  logic           qbit;
  assign rsh  = {rem_q, num_q[NumW-1]};
  assign qbit = rsh >= {1'b0, den_q};

  logic [MagW-1:0] interp;
  assign interp = sign_q ? {vprev_q[ValW-1], vprev_q} - num_q[MagW-1:0]
                         : {vprev_q[ValW-1], vprev_q} + num_q[MagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      time_q   <= '0;
      loop_q   <= 1'b0;
      ovalid_q <= 1'b0;
      k_q      <= '0;
      j_q      <= '0;
      dcnt_q   <= '0;
      op_q     <= OpTick;
    end else begin
      if (cfg_we_i) begin
        loop_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        op_q <= op_i;
        k_q  <= '0;
        if (op_i == OpTick) begin
          time_q <= time_q + TimeW'(1);
        end
      end
      if (cmd_i.k_inc) begin
        k_q <= k_q + CW'(1);
      end
      if (cmd_i.set_j) begin
        j_q <= count_q;
      end
      if (cmd_i.sh_wr) begin
        j_q <= j_m1;
      end
      if (cmd_i.ins_wr) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.div_init) begin
        dcnt_q <= DivCntW'(NumW);
      end
      if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - DivCntW'(1);
      end
      if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        ovalid_q <= 1'b1;
        if (cmd_i.res_sel == ResLoop) begin
          time_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      et_q <= entry_time_i;
      ev_q <= entry_value_i;
    end
    if (cmd_i.capture) begin
      if (t_rdata >= target) begin
        tcur_q <= t_rdata;
        vcur_q <= v_rdata;
      end else begin
        tprev_q <= t_rdata;
        vprev_q <= v_rdata;
      end
      if (k_q == '0) begin
        vfirst_q <= v_rdata;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= mag * dt;
      sign_q <= dv[MagW-1];
      den_q  <= tcur_q - tprev_q;
    end
    if (cmd_i.div_init) begin
      num_q <= {1'b0, prod_q} + NumW'(den_q >> 1);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      // the remainder stays below the divisor, so it fits the time width
      rem_q <= qbit ? TimeW'(rsh - {1'b0, den_q}) : rsh[TimeW-1:0];
      num_q <= {num_q[NumW-2:0], qbit};
    end
    if (cmd_i.out_load) begin
      otime_q <= (cmd_i.res_sel == ResLoop) ? '0 : time_q;
      case (cmd_i.res_sel)
        ResEmpty: begin
          oval_q  <= '0;
          ostat_q <= StatusEmpty;
        end
        ResFull: begin
          oval_q  <= '0;
          ostat_q <= StatusFull;
        end
        ResCur: begin
          oval_q  <= vcur_q;
          ostat_q <= StatusOk;
        end
        ResPrev: begin
          oval_q  <= vprev_q;
          ostat_q <= StatusOk;
        end
        ResLoop: begin
          oval_q  <= vfirst_q;
          ostat_q <= StatusOk;
        end
        ResInterp: begin
          oval_q  <= interp[ValW-1:0];
          ostat_q <= StatusOk;
        end
        default: begin
          oval_q  <= '0;
          ostat_q <= StatusOk;
        end
      endcase
    end
  end

  always_comb begin
    stat_o.op_load    = op_q;
    stat_o.count_zero = count_q == '0;
    stat_o.full       = count_q >= CW'(TableDepth);
    stat_o.k_at_end   = k_q == count_q;
    stat_o.k_zero     = k_q == '0;
    stat_o.hit        = t_rdata >= target;
    stat_o.eq         = t_rdata == target;
    stat_o.j_at_i     = j_q == k_q;
    stat_o.den_zero   = den_q == '0;
    stat_o.div_done   = dcnt_q == '0;
    stat_o.out_free   = !ovalid_q || out_ready_i;
    stat_o.loop       = loop_q;
  end

  assign out_valid_o = ovalid_q;
  assign value_out_o = oval_q;
  assign time_out_o  = otime_q;
  assign status_o    = ostat_q;
endmodule

// ----- design/breakpoint_interpolation_player.sv -----
// top level of the breakpoint interpolation player
// One transaction at a time. A load scans the sorted table entry by entry and, for a
// new time, shifts the entries above the insertion point up by one. A tick scans
// the table the same way; between two breakpoints it adds a multiply step and a
// restoring divider. The table memories have one read and one write port, which
// sets the scan and shift rate. The table needs no clearing after reset. The result
// register lets the next transaction start while a result waits.
module breakpoint_interpolation_player #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [bip_pkg::TimeW-1:0]       entry_time_i,
  input  logic signed [bip_pkg::ValW-1:0] entry_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [bip_pkg::ValW-1:0] value_out_o,
  output logic [bip_pkg::TimeW-1:0]       time_out_o,
  output logic [bip_pkg::StatusW-1:0]     status_o
);
  import bip_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bip_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .stat_i(stat), .cmd_o(cmd)
  );

  bip_dp #(.TableDepth(TABLE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .op_i, .entry_time_i, .entry_value_i,
    .out_valid_o, .out_ready_i, .value_out_o, .time_out_o, .status_o,
    .cmd_i(cmd), .stat_o(stat)
  );
endmodule

// ----- design/bip_checker.sv -----
// port level checks of the breakpoint interpolation player, bound to the top level
module bip_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [bip_pkg::ValW-1:0] value_out_o,
  input logic [bip_pkg::TimeW-1:0]       time_out_o,
  input logic [bip_pkg::StatusW-1:0]     status_o
);
  import bip_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_out_o)
      && $stable(time_out_o) && $stable(status_o))
    else $error("stalled result changed");

  // one transaction in flight
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == StatusOk || status_o == StatusEmpty
      || status_o == StatusFull)
    else $error("bad status code");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusOk |-> value_out_o == '0)
    else $error("nonzero value on error status");
endmodule

bind breakpoint_interpolation_player bip_checker u_bip_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .value_out_o, .time_out_o, .status_o
);
